[sv/bbfa_pkg.sv]
// ----------------------------------------------------------------------------
// bbfa_pkg
// Shared constants and types of the bitmap best-fit block allocator.
// ----------------------------------------------------------------------------
package bbfa_pkg;

  localparam int NUM_BLOCKS = 128;
  // Block address width into the bitmap memory.
  localparam int BLK_W = $clog2(NUM_BLOCKS);
  // Counters and lengths must hold NUM_BLOCKS + 1 and every 8-bit field value.
  localparam int CNT_W = $clog2(NUM_BLOCKS + 2);
  localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;

  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 8;

  typedef enum logic [1:0] {
    OP_FIND = 2'd0,
    OP_MARK = 2'd1,
    OP_BYTE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_MARK,
    ST_BYTE,
    ST_DONE
  } state_t;

endpackage

[sv/bitmap_best_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_best_fit_block_allocator
// Best-fit search, range marking and byte loading over a used-block bitmap.
// ----------------------------------------------------------------------------
// The bitmap lives in a one-bit-wide synchronous memory of NUM_BLOCKS entries
// with one read and one write port, and find, mark and byte operations walk it
// one block per cycle. One word is taken at a time. A find reads blocks 1 to
// NUM_BLOCKS-1 back to back before its result is put on m_tvalid; a mark
// walks the blocks it writes and a byte write its eight bits. s_tready returns
// in the same cycle that m_tvalid is set for the result. After reset a
// clearing pass writes every entry to free, one a cycle, so s_tready stays low
// until the pass is through. A finished result waits in the output register
// and does not hold up acceptance of the next word; only a second result that
// finishes while the first is still unread waits for it.
module bitmap_best_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // run_size[7:0], range_start[15:8], range_end[23:16], mark_used[24],
  // byte_index[28:25], byte_value[36:29], zero fill[39:37]
  input  logic [bbfa_pkg::S_DATA_W-1:0] s_tdata,
  // operation[1:0]
  input  logic [bbfa_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // found[0], start_block[7:1]
  output logic [bbfa_pkg::M_DATA_W-1:0] m_tdata
);
  import bbfa_pkg::*;

  state_t state, state_next;

  // Latched command.
  logic [7:0] run_size;
  logic [7:0] range_end;
  logic       mark_used;
  logic [3:0] byte_index;
  logic [7:0] byte_value;

  logic [LEN_W-1:0] cnt;

  // Block whose bitmap bit arrives from memory in this cycle.
  logic             p_vld;
  logic             p_end;
  logic [LEN_W-1:0] p_blk;

  logic [LEN_W-1:0] run_len;
  logic [LEN_W-1:0] best_len;
  logic [LEN_W-1:0] best_start;
  logic             have;

  logic       out_found;
  logic [6:0] out_start;

  logic             used_mem [NUM_BLOCKS];
  logic             rd_data;
  logic             mem_we;
  logic [BLK_W-1:0] mem_wa;
  logic             mem_wd;
  logic [BLK_W-1:0] mem_ra;

  logic             accept;
  logic [LEN_W-1:0] byte_blk;
  logic             free_here;
  logic [LEN_W-1:0] want;

  assign accept    = s_tvalid && s_tready;
  assign byte_blk  = LEN_W'({byte_index, cnt[2:0]});
  assign free_here = !p_end && !rd_data;
  assign want      = LEN_W'(run_size);
  assign m_tdata   = {out_start, out_found};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_wa] <= mem_wd;
    end
    rd_data <= used_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = cnt[BLK_W-1:0];
    mem_wd     = 1'b0;
    mem_ra     = cnt[BLK_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (cnt == LEN_W'(NUM_BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (s_tuser)
            OP_FIND: state_next = ST_FIND;
            OP_MARK: state_next = ST_MARK;
            OP_BYTE: state_next = ST_BYTE;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_FIND: begin
        if (p_vld && p_end) begin
          state_next = ST_DONE;
        end
      end
      ST_MARK: begin
        if (cnt < LEN_W'(range_end) && cnt < LEN_W'(NUM_BLOCKS)) begin
          mem_we = 1'b1;
          mem_wd = mark_used;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_BYTE: begin
        mem_wa = byte_blk[BLK_W-1:0];
        mem_wd = byte_value[~cnt[2:0]];
        mem_we = byte_blk < LEN_W'(NUM_BLOCKS);
        if (cnt[2:0] == 3'd7) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      p_vld    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && state_next == ST_IDLE) begin
        m_tvalid  <= 1'b1;
        out_found <= have;
        out_start <= best_start[6:0];
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            run_size   <= s_tdata[7:0];
            range_end  <= s_tdata[23:16];
            mark_used  <= s_tdata[24];
            byte_index <= s_tdata[28:25];
            byte_value <= s_tdata[36:29];
            have       <= 1'b0;
            run_len    <= '0;
            best_len   <= '0;
            best_start <= '0;
            p_vld      <= 1'b0;
            if (s_tuser == OP_MARK) begin
              cnt <= LEN_W'(s_tdata[15:8]);
            end else if (s_tuser == OP_FIND) begin
              // Block 0 is reserved and never offered.
              cnt <= LEN_W'(1);
            end else begin
              cnt <= '0;
            end
          end
        end
        ST_FIND: begin
          // One past the last block is a pseudo-used block that closes the
          // final run.
          if (cnt <= LEN_W'(NUM_BLOCKS)) begin
            p_vld <= 1'b1;
            p_blk <= cnt;
            p_end <= (cnt == LEN_W'(NUM_BLOCKS));
            cnt   <= cnt + 1'b1;
          end else begin
            p_vld <= 1'b0;
          end
          if (p_vld) begin
            if (free_here) begin
              run_len <= run_len + 1'b1;
            end else if (run_len != '0) begin
              if (run_len >= want && (!have || run_len < best_len)) begin
                have       <= 1'b1;
                best_len   <= run_len;
                best_start <= p_blk - run_len;
              end
              run_len <= '0;
            end
          end
        end
        ST_CLEAR, ST_MARK, ST_BYTE: begin
          cnt <= cnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[sv/bbfa_checker.sv]
// ----------------------------------------------------------------------------
// bbfa_checker
// Port-level checks of the bitmap best-fit block allocator.
// ----------------------------------------------------------------------------
module bbfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [bbfa_pkg::S_DATA_W-1:0] s_tdata,
  input logic [bbfa_pkg::S_USER_W-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [bbfa_pkg::M_DATA_W-1:0] m_tdata
);
  import bbfa_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed or dropped while stalled");

  // One word at a time: the block is busy right after taking one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while the previous word is in progress");

  // A miss reports block zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
    else $error("start block set without a found run");

  // Block zero is reserved, so a hit never starts there.
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[7:1] != 7'd0)
    else $error("found run starts at the reserved block");

endmodule

bind bitmap_best_fit_block_allocator bbfa_checker u_bbfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
